// ===== hdl/vde_pkg.sv =====
// Shared types and constants for the vector distance engine.
package vde_pkg;

  localparam int AccW = 48;
  localparam int ElemBits = 16;
  localparam logic [1:0] MetricCos = 2'd0;
  localparam logic [1:0] MetricEuc = 2'd1;
  localparam logic [1:0] MetricMan = 2'd2;
  localparam logic [31:0] OneQ14 = 32'd16384;

  typedef struct packed {
    logic signed [15:0] a_elem;
    logic signed [15:0] b_elem;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               zero_norm;
  } out_req_t;

  // One finished vector, handed from the accumulating front to the solver.
  typedef struct packed {
    logic [1:0]             metric;
    logic signed [AccW-1:0] dot;
    logic signed [AccW-1:0] na;
    logic signed [AccW-1:0] nb;
  } job_t;

endpackage

// ===== hdl/vde_front.sv =====
// Front end: accumulate element pairs and emit one job per vector.
module vde_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          metric_i,
  input  logic                in_valid,
  output logic                in_ready,
  input  vde_pkg::in_req_t    in_data,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output vde_pkg::job_t       job_o
);

  localparam int AW = vde_pkg::AccW;
  localparam int ElemBits = vde_pkg::ElemBits;
  localparam logic signed [AW-1:0] AccMax = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] AccMin = {1'b1, {(AW-1){1'b0}}};

  // Stage 1: registered terms (products or absolute differences).
  logic               s1_valid_q, s1_last_q;
  logic [1:0]         s1_metric_q;
  logic signed [AW-1:0] s1_t0_q, s1_t1_q, s1_t2_q;
  logic signed [AW-1:0] dot_q, na_q, nb_q, dot_d, na_d, nb_d;
  logic               jv_q;
  vde_pkg::job_t      job_q;

  logic signed [ElemBits-1:0] a, b;
  logic signed [ElemBits:0]   df;
  logic [ElemBits:0]          ad;
  logic signed [AW-1:0]       t0, t1, t2;

  // Hold the pipe while a finished job waits for the back end.
  logic adv;
  assign adv = !(jv_q && !job_ready_i);
  assign in_ready = adv;

  always_comb begin
    a  = in_data.a_elem[ElemBits-1:0];
    b  = in_data.b_elem[ElemBits-1:0];
    df = (ElemBits+1)'(a) - (ElemBits+1)'(b);
    ad = df[ElemBits] ? (ElemBits+1)'(-df) : df;
    t0 = '0; t1 = '0; t2 = '0;
    case (metric_i)
      vde_pkg::MetricCos: begin
        t0 = AW'((2*ElemBits)'(a) * (2*ElemBits)'(b));
        t1 = AW'((2*ElemBits)'(a) * (2*ElemBits)'(a));
        t2 = AW'((2*ElemBits)'(b) * (2*ElemBits)'(b));
      end
      vde_pkg::MetricEuc: begin
        if ((ElemBits+1 > 24) && ((AW+1)'(ad) >= (AW+1)'(1 << 24))) t0 = AccMax;
        else t0 = AW'((2*ElemBits+2)'(ad) * (2*ElemBits+2)'(ad));
      end
      vde_pkg::MetricMan: t0 = AW'($signed({1'b0, ad}));
      default: ;
    endcase
  end

  function automatic logic signed [AW-1:0] sat_add(logic signed [AW-1:0] x,
                                                    logic signed [AW-1:0] y);
    logic signed [AW:0] s;
    s = (AW+1)'(x) + (AW+1)'(y);
    if (s > (AW+1)'(AccMax)) return AccMax;
    if (s < (AW+1)'(AccMin)) return AccMin;
    return s[AW-1:0];
  endfunction

  always_comb begin
    dot_d = sat_add(dot_q, s1_t0_q);
    na_d  = sat_add(na_q, s1_t1_q);
    nb_d  = sat_add(nb_q, s1_t2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      dot_q <= '0; na_q <= '0; nb_q <= '0;
      jv_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q <= in_valid;
        if (s1_valid_q) begin
          if (s1_last_q) begin
            dot_q <= '0; na_q <= '0; nb_q <= '0;
          end else begin
            dot_q <= dot_d; na_q <= na_d; nb_q <= nb_d;
          end
        end
      end
      jv_q <= (jv_q && !job_ready_i) || (adv && s1_valid_q && s1_last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q   <= in_data.last;
      s1_metric_q <= metric_i;
      s1_t0_q <= t0; s1_t1_q <= t1; s1_t2_q <= t2;
      if (s1_valid_q && s1_last_q) begin
        job_q.metric <= s1_metric_q;
        job_q.dot <= dot_d; job_q.na <= na_d; job_q.nb <= nb_d;
      end
    end
  end

  assign job_valid_o = jv_q;
  assign job_o = job_q;

endmodule

// ===== hdl/vde_back.sv =====
// Back end: roots, multiply, divide and saturation, one job at a time.
module vde_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  vde_pkg::job_t     job_i,
  output logic              out_valid,
  input  logic              out_ready,
  output vde_pkg::out_req_t out_data
);

  localparam logic [2:0] StIdle = 3'd0, StSq1 = 3'd1, StSq2 = 3'd2, StMul = 3'd3,
                         StDiv = 3'd4, StFin = 3'd5, StOut = 3'd6;
  localparam int AW = vde_pkg::AccW;

  logic [2:0]  st_q;
  logic [1:0]  met_q;
  logic        neg_q;
  logic [63:0] x_q, res_q, bit_q;   // isqrt working set
  logic [63:0] s1_q, s2_q;
  logic [63:0] p_q, d_q, r_q, q_q;  // divider working set
  logic [6:0]  cnt_q;
  logic [47:0] dabs;
  logic [63:0] rs, rsh;
  vde_pkg::out_req_t o_q;
  logic [31:0] mh;   // multiplier operand, split in halves for the multiply
  logic [63:0] pp_q;

  assign job_ready_o = (st_q == StIdle);
  assign out_valid = (st_q == StOut);
  assign out_data = o_q;
  assign dabs = job_i.dot[AW-1] ? 48'(-job_i.dot) : 48'(job_i.dot);
  assign rs = res_q + bit_q;
  assign rsh = {r_q[62:0], 1'b0};
  assign mh = s2_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      case (st_q)
        StIdle: begin
          if (job_valid_i) begin
            met_q <= job_i.metric;
            neg_q <= job_i.dot[AW-1];
            d_q   <= 64'(dabs);
            res_q <= '0; bit_q <= 64'd1 << 62; cnt_q <= '0;
            o_q   <= '0;
            case (job_i.metric)
              vde_pkg::MetricCos: begin
                if (job_i.na <= 0 || job_i.nb <= 0) begin
                  o_q.zero_norm <= 1'b1; st_q <= StOut;
                end else begin
                  x_q <= {job_i.na, 16'd0}; p_q <= {job_i.nb, 16'd0}; st_q <= StSq1;
                end
              end
              vde_pkg::MetricEuc: begin
                x_q <= job_i.dot[AW-1] ? 64'd0 : 64'(job_i.dot); st_q <= StSq1;
              end
              vde_pkg::MetricMan: begin
                if (job_i.dot > 48'sh7FFFFFFF) o_q.value <= 32'h7FFFFFFF;
                else if (job_i.dot < -48'sh80000000) o_q.value <= 32'h80000000;
                else o_q.value <= job_i.dot[31:0];
                st_q <= StOut;
              end
              default: st_q <= StOut;
            endcase
          end
        end
        StSq1, StSq2: begin
          // Shift-and-subtract root; bit_q walks down two places a step.
          if (bit_q != 0) begin
            if (x_q >= rs) begin
              x_q <= x_q - rs; res_q <= (res_q >> 1) + bit_q;
            end else res_q <= res_q >> 1;
            bit_q <= bit_q >> 2;
          end else if (met_q == vde_pkg::MetricEuc) begin
            o_q.value <= (x_q > res_q) ? 32'(res_q + 1) : 32'(res_q);
            st_q <= StOut;
          end else if (st_q == StSq1) begin
            s1_q <= res_q; x_q <= p_q; res_q <= '0; bit_q <= 64'd1 << 62;
            st_q <= StSq2;
          end else begin
            s2_q <= res_q; cnt_q <= '0; st_q <= StMul;
          end
        end
        StMul: begin
          // Roots fit in 32 bits; two half products, the first held in pp_q.
          if (cnt_q == 0) begin
            pp_q <= 64'(48'(s1_q[31:0]) * 48'(mh[15:0])); cnt_q <= 7'd1;
          end else begin
            p_q <= pp_q + (64'(48'(s1_q[31:0]) * 48'(mh[31:16])) << 16);
            r_q <= '0; q_q <= '0; cnt_q <= '0; st_q <= StDiv;
          end
        end
        StDiv: begin
          // Restoring divide of d * 2^31 by p, one quotient bit a cycle.
          begin
            logic [63:0] rn;
            rn = (cnt_q < 7'd48) ? (rsh | 64'(d_q[47 - cnt_q[5:0]])) : rsh;
            if (rn >= p_q) begin
              r_q <= rn - p_q; q_q <= {q_q[62:0], 1'b1};
            end else begin
              r_q <= rn; q_q <= {q_q[62:0], 1'b0};
            end
          end
          if (cnt_q == 7'd78) st_q <= StFin;
          cnt_q <= cnt_q + 7'd1;
        end
        StFin: begin
          begin
            logic [63:0] qr;
            qr = (q_q + 64'd1) >> 1;
            if (q_q[63:32] >= 32'd1 || qr > 64'(vde_pkg::OneQ14)) qr = 64'(vde_pkg::OneQ14);
            o_q.value <= neg_q ? -32'(qr) : 32'(qr);
          end
          st_q <= StOut;
        end
        StOut: if (out_ready) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hdl/vector_distance_engine.sv =====
// Top level of the vector distance engine.
// Streams element pairs (one request per cycle while in_ready is high) into
// a front end that keeps three saturating 48-bit accumulators: dot/sum, and
// the two squared norms. The last pair of a vector hands a finished job to a
// one-entry queue and the accumulators clear, so the next vector starts at
// once unless the queued job still waits for the back end. The back end forms
// the result: euclidean takes one root (one bit-pair root step a cycle), cosine
// two roots, a two-step multiply and a bit-serial divide; manhattan and
// zero-norm cases need none. The metric is sampled with each entering pair.
module vector_distance_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid,
  output logic               in_ready,
  input  vde_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vde_pkg::out_req_t  out_data
);

  logic [1:0]    metric_q;
  logic          jv, jr;
  vde_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) metric_q <= vde_pkg::MetricCos;
    else if (cfg_we_i) metric_q <= cfg_wdata_i;
  end

  vde_front u_front (
    .clk_i, .rst_ni, .metric_i(metric_q), .in_valid, .in_ready, .in_data,
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  vde_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .out_valid, .out_ready, .out_data
  );

endmodule
